// ===== rtl/core/lsfb_pkg.sv =====
package lsfb_pkg;

    // Store geometry and frame layout.
    localparam int STORE_DEPTH = 8;
    localparam int LED_COUNT = 8;
    localparam int FRAME_PIXELS = (LED_COUNT < STORE_DEPTH) ? LED_COUNT : STORE_DEPTH;
    localparam int HEADER_BYTES = 4;
    localparam int FRAME_BYTES = HEADER_BYTES + 4 * FRAME_PIXELS;
    localparam int PIX_W = $clog2(STORE_DEPTH);
    localparam int CNT_W = $clog2(HEADER_BYTES + 4 * STORE_DEPTH);

    localparam logic [31:0] DEFAULT_WORD = 32'h0000_0003;
    localparam logic [7:0] START_MARK = 8'hE0;

    // Command queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Command codes as they arrive on the input channel.
    localparam logic [2:0] CMD_WRITE_PARTS = 3'd0;
    localparam logic [2:0] CMD_WRITE_WORD = 3'd1;
    localparam logic [2:0] CMD_SHOW = 3'd2;
    localparam logic [2:0] CMD_FADE = 3'd3;
    localparam logic [2:0] CMD_SET_LEVEL = 3'd4;
    localparam logic [2:0] CMD_READ = 3'd5;

    // Result kinds on the output channel.
    localparam logic KIND_FRAME = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // Decoded operations handed to the back end.
    typedef enum logic [2:0] {
        OP_WRITE,
        OP_SHOW,
        OP_FADE,
        OP_LEVEL,
        OP_READ
    } op_t;

    typedef struct packed {
        op_t op;
        logic [PIX_W-1:0] index;
        logic [31:0] data;
    } cmd_t;

    typedef enum logic {
        BK_IDLE,
        BK_FRAME
    } back_state_t;

endpackage

// ===== rtl/core/lsfb_front.sv =====
module lsfb_front (
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [2:0]            command,
    input  logic [2:0]            index,
    input  logic [7:0]            red,
    input  logic [7:0]            green,
    input  logic [7:0]            blue,
    input  logic [2:0]            bright,
    input  logic [4:0]            level,
    input  logic [31:0]           word_in,
    input  logic                  q_full,
    output logic                  q_push,
    output lsfb_pkg::cmd_t        q_cmd
);

    logic known;

    // Classify the beat and build the word or level that the back end applies.
    always_comb begin
        known = 1'b1;
        q_cmd.op = lsfb_pkg::OP_SHOW;
        q_cmd.index = index;
        q_cmd.data = 32'd0;
        case (command)
            lsfb_pkg::CMD_WRITE_PARTS: begin
                q_cmd.op = lsfb_pkg::OP_WRITE;
                q_cmd.data = {red, green, blue, 5'd0, bright};
            end
            lsfb_pkg::CMD_WRITE_WORD: begin
                q_cmd.op = lsfb_pkg::OP_WRITE;
                q_cmd.data = word_in;
            end
            lsfb_pkg::CMD_SHOW: begin
                q_cmd.op = lsfb_pkg::OP_SHOW;
            end
            lsfb_pkg::CMD_FADE: begin
                q_cmd.op = lsfb_pkg::OP_FADE;
            end
            lsfb_pkg::CMD_SET_LEVEL: begin
                q_cmd.op = lsfb_pkg::OP_LEVEL;
                q_cmd.data = {27'd0, level};
            end
            lsfb_pkg::CMD_READ: begin
                q_cmd.op = lsfb_pkg::OP_READ;
            end
            default: begin
                known = 1'b0;
            end
        endcase
    end

    // Unused command codes are taken and dropped.
    assign s_tready = !q_full;
    assign q_push = s_tvalid && !q_full && known;

endmodule

// ===== rtl/core/lsfb_queue.sv =====
module lsfb_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  lsfb_pkg::cmd_t        push_cmd,
    output logic                  full,
    input  logic                  pop,
    output logic                  valid,
    output lsfb_pkg::cmd_t        head_cmd
);

    lsfb_pkg::cmd_t entry_reg [lsfb_pkg::QUEUE_DEPTH];
    logic [lsfb_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [lsfb_pkg::QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [lsfb_pkg::QUEUE_CNT_W-1:0] count_reg, count_next;

    assign full = (count_reg == lsfb_pkg::QUEUE_CNT_W'(lsfb_pkg::QUEUE_DEPTH));
    assign valid = (count_reg != '0);
    assign head_cmd = entry_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == lsfb_pkg::QUEUE_PTR_W'(lsfb_pkg::QUEUE_DEPTH - 1))
                ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == lsfb_pkg::QUEUE_PTR_W'(lsfb_pkg::QUEUE_DEPTH - 1))
                ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== rtl/core/lsfb_back.sv =====
module lsfb_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_valid,
    input  lsfb_pkg::cmd_t        q_cmd,
    output logic                  q_pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [47:0]           m_tdata,
    output logic                  m_tuser,
    output logic                  m_tlast
);

    localparam logic [lsfb_pkg::CNT_W-1:0] LAST_CNT =
        lsfb_pkg::CNT_W'(lsfb_pkg::FRAME_BYTES - 1);

    lsfb_pkg::back_state_t state_reg, state_next;
    logic [lsfb_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic frame_dark_reg, frame_dark_next;
    logic [31:0] store_reg [lsfb_pkg::STORE_DEPTH];
    logic [31:0] store_next [lsfb_pkg::STORE_DEPTH];

    logic out_valid_reg, out_valid_next;
    logic out_kind_reg, out_kind_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic out_last_reg, out_last_next;
    logic [31:0] out_word_reg, out_word_next;
    logic out_dark_reg, out_dark_next;

    logic ready_out;
    logic [lsfb_pkg::CNT_W-1:0] body_off;
    logic [lsfb_pkg::PIX_W-1:0] rd_addr;
    logic [31:0] rd_word;
    logic [7:0] frame_byte;
    logic [2:0] faded;
    logic fade_dark;

    // The output register takes a new beat when empty or being drained.
    assign ready_out = !out_valid_reg || m_tready;

    // One read port on the store, shared by frame and read commands.
    assign body_off = cnt_reg - lsfb_pkg::CNT_W'(lsfb_pkg::HEADER_BYTES);
    assign rd_addr = (state_reg == lsfb_pkg::BK_FRAME) ? body_off[lsfb_pkg::PIX_W+1:2]
                                                       : q_cmd.index;
    assign rd_word = store_reg[rd_addr];

    // Frame byte for the current position.
    always_comb begin
        frame_byte = 8'd0;
        if (cnt_reg >= lsfb_pkg::CNT_W'(lsfb_pkg::HEADER_BYTES)) begin
            case (body_off[1:0])
                2'd0: frame_byte = lsfb_pkg::START_MARK | {3'd0, rd_word[4:0]};
                2'd1: frame_byte = rd_word[15:8];
                2'd2: frame_byte = rd_word[23:16];
                2'd3: frame_byte = rd_word[31:24];
                default: frame_byte = 8'd0;
            endcase
        end
    end

    // Sequencer: take one command, then update the store, emit a read beat or stream the frame.
    always_comb begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        frame_dark_next = frame_dark_reg;
        store_next = store_reg;
        q_pop = 1'b0;
        fade_dark = 1'b1;
        faded = 3'd0;
        out_valid_next = out_valid_reg && !m_tready;
        out_kind_next = out_kind_reg;
        out_byte_next = out_byte_reg;
        out_last_next = out_last_reg;
        out_word_next = out_word_reg;
        out_dark_next = out_dark_reg;
        case (state_reg)
            lsfb_pkg::BK_IDLE: begin
                if (q_valid && ready_out) begin
                    q_pop = 1'b1;
                    cnt_next = '0;
                    frame_dark_next = 1'b0;
                    case (q_cmd.op)
                        lsfb_pkg::OP_WRITE: begin
                            store_next[q_cmd.index] = q_cmd.data;
                        end
                        lsfb_pkg::OP_SHOW: begin
                            state_next = lsfb_pkg::BK_FRAME;
                        end
                        lsfb_pkg::OP_FADE: begin
                            for (int i = 0; i < lsfb_pkg::STORE_DEPTH; i++) begin
                                faded = (store_reg[i][2:0] == 3'd0) ? 3'd0
                                                                    : store_reg[i][2:0] - 3'd1;
                                if (faded != 3'd0) begin
                                    fade_dark = 1'b0;
                                end
                                store_next[i] = {store_reg[i][31:8], 5'd0, faded};
                            end
                            frame_dark_next = fade_dark;
                            state_next = lsfb_pkg::BK_FRAME;
                        end
                        lsfb_pkg::OP_LEVEL: begin
                            for (int i = 0; i < lsfb_pkg::STORE_DEPTH; i++) begin
                                store_next[i] = {store_reg[i][31:8], 3'd0, q_cmd.data[4:0]};
                            end
                            state_next = lsfb_pkg::BK_FRAME;
                        end
                        lsfb_pkg::OP_READ: begin
                            out_valid_next = 1'b1;
                            out_kind_next = lsfb_pkg::KIND_READ;
                            out_byte_next = 8'd0;
                            out_last_next = 1'b0;
                            out_word_next = rd_word;
                            out_dark_next = 1'b0;
                        end
                        default: begin
                            state_next = lsfb_pkg::BK_IDLE;
                        end
                    endcase
                end
            end
            lsfb_pkg::BK_FRAME: begin
                if (ready_out) begin
                    out_valid_next = 1'b1;
                    out_kind_next = lsfb_pkg::KIND_FRAME;
                    out_byte_next = frame_byte;
                    out_last_next = (cnt_reg == LAST_CNT);
                    out_word_next = 32'd0;
                    out_dark_next = frame_dark_reg;
                    if (cnt_reg == LAST_CNT) begin
                        state_next = lsfb_pkg::BK_IDLE;
                    end else begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = lsfb_pkg::BK_IDLE;
            end
        endcase
    end

    // Control state and the pixel store.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lsfb_pkg::BK_IDLE;
            cnt_reg <= '0;
            frame_dark_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < lsfb_pkg::STORE_DEPTH; i++) begin
                store_reg[i] <= lsfb_pkg::DEFAULT_WORD;
            end
        end else begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            frame_dark_reg <= frame_dark_next;
            out_valid_reg <= out_valid_next;
            store_reg <= store_next;
        end
    end

    // Output payload register.
    always_ff @(posedge aclk) begin
        out_kind_reg <= out_kind_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        out_word_reg <= out_word_next;
        out_dark_reg <= out_dark_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser = out_kind_reg;
    assign m_tlast = out_last_reg;
    assign m_tdata = {7'd0, out_dark_reg, out_word_reg, out_byte_reg};

    // The frame counter never runs past the end of a frame.
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == lsfb_pkg::BK_FRAME |-> cnt_reg <= LAST_CNT)
        else $error("frame counter past end of frame");

    // Loading the final frame byte ends the frame and marks the beat as last.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == lsfb_pkg::BK_FRAME && ready_out && cnt_reg == LAST_CNT)
        |=> (state_reg == lsfb_pkg::BK_IDLE && out_valid_reg && out_last_reg))
        else $error("frame did not close on its last byte");

    // Commands are taken from the queue only between frames.
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> (state_reg == lsfb_pkg::BK_IDLE && q_valid))
        else $error("queue popped during a frame or while empty");

    // A read beat never carries frame markers.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_kind_reg == lsfb_pkg::KIND_READ)
        |-> (!out_last_reg && !out_dark_reg && out_byte_reg == 8'd0))
        else $error("read beat carries frame fields");

endmodule

// ===== rtl/core/led_strip_frame_builder_top.sv =====
// LED strip frame builder.
// The input channel (s_*) carries one command per beat: writes of a pixel
// from its parts or as a whole word, show, fade step, set all level, and
// read. Command codes six and seven are accepted and dropped.
// The output channel (m_*) carries frame bytes (m_tuser low) with m_tlast
// on the final byte, or one read beat (m_tuser high) with the pixel word.
// A frame is 4 + 4 * FRAME_PIXELS bytes (LED_COUNT capped at STORE_DEPTH),
// 36 for eight LEDs, sent one byte per cycle while m_tready is high; the
// frame byte sequencer in the back end sets the byte count. A write or read
// is handled in the idle state; a show, fade or set all level command then
// streams its frame from the frame state. A command is registered in the queue
// before the back end pops it into the output register or the frame state.
// A two-entry command queue sits between the decoder and the back end, so
// the input takes up to two commands while a frame streams out.
// When the receiver stalls, the output register holds its beat and the
// frame pauses; the queue fills and then s_tready drops.
// Reset sets every pixel word to 0x00000003 and empties the queue.
module led_strip_frame_builder_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // index, red, green, blue, bright, level, word_in, zero padding
    input  logic [71:0] s_tdata,
    // command
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // out_byte, pixel_word, all_dark, zero padding
    output logic [47:0] m_tdata,
    // result_kind
    output logic        m_tuser,
    output logic        m_tlast
);

    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_valid;
    lsfb_pkg::cmd_t push_cmd;
    lsfb_pkg::cmd_t head_cmd;

    // Decode commands into the queue.
    lsfb_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .command  (s_tuser),
        .index    (s_tdata[2:0]),
        .red      (s_tdata[10:3]),
        .green    (s_tdata[18:11]),
        .blue     (s_tdata[26:19]),
        .bright   (s_tdata[29:27]),
        .level    (s_tdata[34:30]),
        .word_in  (s_tdata[66:35]),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    // Command queue.
    lsfb_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .head_cmd (head_cmd)
    );

    // Pixel store and frame streaming.
    lsfb_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_cmd    (head_cmd),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== tb/lsfb_checker.sv =====
`timescale 1ns / 100ps

// Watches both stream channels of the LED strip frame builder, keeps its own
// copy of the pixel store and compares every output beat with the oldest
// expected one.
module lsfb_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    // index, red, green, blue, bright, level, word_in, zero padding
    input  logic [71:0] s_tdata,
    // command
    input  logic [2:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    // out_byte, pixel_word, all_dark, zero padding
    input  logic [47:0] m_tdata,
    // result_kind
    input  logic        m_tuser,
    input  logic        m_tlast,
    output int          mismatch_count,
    output int          pending_beats
);

    typedef struct packed {
        logic        kind;
        logic [7:0]  frame_byte;
        logic        last;
        logic [31:0] word;
        logic        dark;
    } led_beat_t;

    logic [31:0] pixel_copy [lsfb_pkg::STORE_DEPTH];
    led_beat_t   beat_q [$];

    initial begin
        mismatch_count = 0;
        pending_beats = 0;
    end

    task automatic add_beat(input logic kind, input logic [7:0] fb, input logic last,
                            input logic [31:0] word, input logic dark);
        led_beat_t b;
        b.kind = kind;
        b.frame_byte = fb;
        b.last = last;
        b.word = word;
        b.dark = dark;
        beat_q = {beat_q, b};
    endtask

    // Header of zero bytes, then marker, blue, green and red for each LED.
    task automatic queue_frame(input logic dark);
        logic [31:0] w;
        for (int n = 0; n < lsfb_pkg::HEADER_BYTES; n++)
            add_beat(lsfb_pkg::KIND_FRAME, 8'h00, 1'b0, 32'h0, dark);
        for (int n = 0; n < lsfb_pkg::FRAME_PIXELS; n++) begin
            w = pixel_copy[n];
            add_beat(lsfb_pkg::KIND_FRAME, lsfb_pkg::START_MARK | {3'b000, w[4:0]}, 1'b0,
                     32'h0, dark);
            add_beat(lsfb_pkg::KIND_FRAME, w[15:8], 1'b0, 32'h0, dark);
            add_beat(lsfb_pkg::KIND_FRAME, w[23:16], 1'b0, 32'h0, dark);
            add_beat(lsfb_pkg::KIND_FRAME, w[31:24], n == lsfb_pkg::FRAME_PIXELS - 1,
                     32'h0, dark);
        end
    endtask

    // Update the pixel copy for one accepted command and queue its results.
    task automatic apply_command(input logic [2:0] cmd, input logic [71:0] d);
        logic [lsfb_pkg::PIX_W-1:0] idx;
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
        logic [2:0]       bright;
        logic [4:0]       level;
        logic [31:0]      word_in;
        logic [2:0]       b;
        logic             dark;
        idx = d[2:0];
        red = d[10:3];
        green = d[18:11];
        blue = d[26:19];
        bright = d[29:27];
        level = d[34:30];
        word_in = d[66:35];
        case (cmd)
            lsfb_pkg::CMD_WRITE_PARTS: begin
                pixel_copy[idx] = {red, green, blue, 5'b00000, bright};
            end
            lsfb_pkg::CMD_WRITE_WORD: begin
                pixel_copy[idx] = word_in;
            end
            lsfb_pkg::CMD_SHOW: begin
                queue_frame(1'b0);
            end
            lsfb_pkg::CMD_FADE: begin
                // Each working brightness drops by one and stops at zero.
                dark = 1'b1;
                for (int i = 0; i < lsfb_pkg::STORE_DEPTH; i++) begin
                    b = pixel_copy[i][2:0];
                    if (b != 3'd0) b = b - 3'd1;
                    if (b != 3'd0) dark = 1'b0;
                    pixel_copy[i] = {pixel_copy[i][31:8], 5'b00000, b};
                end
                queue_frame(dark);
            end
            lsfb_pkg::CMD_SET_LEVEL: begin
                for (int i = 0; i < lsfb_pkg::STORE_DEPTH; i++)
                    pixel_copy[i] = {pixel_copy[i][31:8], 3'b000, level};
                queue_frame(1'b0);
            end
            lsfb_pkg::CMD_READ: begin
                add_beat(lsfb_pkg::KIND_READ, 8'h00, 1'b0, pixel_copy[idx], 1'b0);
            end
            default: begin
                // Unused codes are dropped without a result.
            end
        endcase
    endtask

    task automatic flag_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    // Inputs first, then outputs: no result can leave in the cycle its command arrives.
    always @(posedge aclk) begin
        led_beat_t want;
        if (!aresetn) begin
            for (int i = 0; i < lsfb_pkg::STORE_DEPTH; i++)
                pixel_copy[i] = lsfb_pkg::DEFAULT_WORD;
            beat_q.delete();
        end else begin
            if (s_tvalid && s_tready) apply_command(s_tuser, s_tdata);
            if (m_tvalid && m_tready) begin
                if (beat_q.size() == 0) begin
                    $display("%0t: unexpected beat, expected none, actual kind %0b data %h last %0b",
                             $time, m_tuser, m_tdata, m_tlast);
                    mismatch_count++;
                end else begin
                    want = beat_q.pop_front();
                    flag_field("result_kind", 32'(want.kind), 32'(m_tuser));
                    flag_field("out_byte", 32'(want.frame_byte), 32'(m_tdata[7:0]));
                    flag_field("last_byte", 32'(want.last), 32'(m_tlast));
                    flag_field("pixel_word", want.word, m_tdata[39:8]);
                    flag_field("all_dark", 32'(want.dark), 32'(m_tdata[40]));
                end
            end
        end
        pending_beats <= beat_q.size();
    end

endmodule

// ===== tb/tb_led_strip_frame_builder_top.sv =====
`timescale 1ns / 100ps

module tb_led_strip_frame_builder_top;

    // Codes the block accepts and drops.
    localparam logic [2:0] CMD_UNUSED_LO = 3'd6;
    localparam logic [2:0] CMD_UNUSED_HI = 3'd7;
    localparam int PHASE_ITEMS = 84;
    localparam int DRAIN_CYCLES = 40;
    localparam int LONG_HOLD_CYCLES = 400;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic [2:0]  s_tuser = lsfb_pkg::CMD_SHOW;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    int mismatch_count;
    int pending_beats;
    int items_sent = 0;
    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    bit hold_req = 1'b0;
    int hold_left = LONG_HOLD_CYCLES;

    always #5 aclk = ~aclk;

    led_strip_frame_builder_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    lsfb_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast),
        .mismatch_count(mismatch_count),
        .pending_beats (pending_beats)
    );

    // Receiver: a single long hold-off when requested, otherwise random stalls.
    always @(posedge aclk) begin
        if (hold_req && hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    function automatic logic [71:0] pack_item(input logic [2:0] idx, input logic [7:0] red,
                                              input logic [7:0] green, input logic [7:0] blue,
                                              input logic [2:0] bright, input logic [4:0] level,
                                              input logic [31:0] word_in);
        return {5'b00000, word_in, level, bright, blue, green, red, idx};
    endfunction

    function automatic logic [71:0] random_payload();
        return pack_item(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                         3'($urandom_range(0, 7)), 5'($urandom_range(0, 31)),
                         $urandom());
    endfunction

    // Offer one beat after an optional random gap and wait until it is taken.
    task automatic send_cmd(input logic [2:0] cmd, input logic [71:0] payload);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= payload;
        s_tuser <= cmd;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic send_random();
        int pick;
        logic [2:0] cmd;
        pick = $urandom_range(0, 99);
        if (pick < 22) cmd = lsfb_pkg::CMD_WRITE_PARTS;
        else if (pick < 40) cmd = lsfb_pkg::CMD_WRITE_WORD;
        else if (pick < 52) cmd = lsfb_pkg::CMD_SHOW;
        else if (pick < 64) cmd = lsfb_pkg::CMD_FADE;
        else if (pick < 74) cmd = lsfb_pkg::CMD_SET_LEVEL;
        else if (pick < 94) cmd = lsfb_pkg::CMD_READ;
        else if (pick < 97) cmd = CMD_UNUSED_LO;
        else cmd = CMD_UNUSED_HI;
        send_cmd(cmd, random_payload());
    endtask

    // Random traffic with occasional fade runs long enough to darken the strip.
    task automatic run_phase(input int idle_pct, input int stall_pct);
        int phase_end;
        src_idle_pct = idle_pct;
        sink_stall_pct = stall_pct;
        phase_end = items_sent + PHASE_ITEMS;
        while (items_sent < phase_end) begin
            if ($urandom_range(0, 99) < 5) begin
                repeat (8) send_cmd(lsfb_pkg::CMD_FADE, random_payload());
            end else begin
                send_random();
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part: reset contents, field extremes, fades down to dark.
        send_cmd(lsfb_pkg::CMD_READ,
                 pack_item(3'd0, 8'h00, 8'h00, 8'h00, 3'd0, 5'd0, 32'h0));
        send_cmd(lsfb_pkg::CMD_READ,
                 pack_item(3'd7, 8'h00, 8'h00, 8'h00, 3'd0, 5'd0, 32'h0));
        send_cmd(lsfb_pkg::CMD_SHOW, '0);
        send_cmd(lsfb_pkg::CMD_WRITE_PARTS,
                 pack_item(3'd0, 8'h00, 8'h00, 8'h00, 3'd0, 5'd0, 32'h0));
        send_cmd(lsfb_pkg::CMD_WRITE_PARTS,
                 pack_item(3'd7, 8'hFF, 8'hFF, 8'hFF, 3'd7, 5'd31, 32'hFFFF_FFFF));
        send_cmd(lsfb_pkg::CMD_WRITE_WORD,
                 pack_item(3'd3, 8'h00, 8'h00, 8'h00, 3'd0, 5'd0, 32'hFFFF_FFFF));
        send_cmd(lsfb_pkg::CMD_WRITE_WORD,
                 pack_item(3'd4, 8'hFF, 8'hFF, 8'hFF, 3'd7, 5'd31, 32'h0));
        send_cmd(lsfb_pkg::CMD_READ,
                 pack_item(3'd3, 8'h00, 8'h00, 8'h00, 3'd0, 5'd0, 32'h0));
        send_cmd(lsfb_pkg::CMD_READ,
                 pack_item(3'd7, 8'h00, 8'h00, 8'h00, 3'd0, 5'd0, 32'h0));
        send_cmd(lsfb_pkg::CMD_READ,
                 pack_item(3'd0, 8'h00, 8'h00, 8'h00, 3'd0, 5'd0, 32'h0));
        send_cmd(lsfb_pkg::CMD_SHOW, '0);
        send_cmd(lsfb_pkg::CMD_FADE, '0);
        send_cmd(lsfb_pkg::CMD_SET_LEVEL,
                 pack_item(3'd0, 8'h00, 8'h00, 8'h00, 3'd0, 5'd31, 32'h0));
        send_cmd(lsfb_pkg::CMD_SHOW, '0);
        send_cmd(lsfb_pkg::CMD_SET_LEVEL,
                 pack_item(3'd0, 8'h00, 8'h00, 8'h00, 3'd0, 5'd0, 32'h0));
        send_cmd(lsfb_pkg::CMD_FADE, '0);
        send_cmd(lsfb_pkg::CMD_SET_LEVEL,
                 pack_item(3'd0, 8'h00, 8'h00, 8'h00, 3'd0, 5'd1, 32'h0));
        send_cmd(lsfb_pkg::CMD_FADE, '0);
        send_cmd(CMD_UNUSED_LO, random_payload());
        send_cmd(CMD_UNUSED_HI, random_payload());
        send_cmd(lsfb_pkg::CMD_READ,
                 pack_item(3'd4, 8'h00, 8'h00, 8'h00, 3'd0, 5'd0, 32'h0));
        send_cmd(lsfb_pkg::CMD_WRITE_WORD,
                 pack_item(3'd5, 8'h00, 8'h00, 8'h00, 3'd0, 5'd0, 32'h5AA5_C3E7));
        send_cmd(lsfb_pkg::CMD_SHOW, '0);

        // Receiver holds off while frames keep coming, so the input backs up.
        hold_req = 1'b1;
        repeat (6) send_cmd(lsfb_pkg::CMD_SHOW, random_payload());
        run_phase(0, 0);
        run_phase(79, 0);
        run_phase(0, 79);
        run_phase(18, 18);
        s_tvalid <= 1'b0;

        // Let the checker see the last accepted command before draining.
        @(posedge aclk);
        while (pending_beats != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && pending_beats == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
